### src/sipq_pkg.sv
`default_nettype none
package sipq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_ORDER    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key;
    } t_req;

    typedef struct packed {
        logic [31:0] front_key;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic                 mode;
        logic [KEY_WIDTH-1:0] key;
    } t_cell_ctl;

endpackage
`default_nettype wire

### src/sipq_cell.sv
`default_nettype none
module sipq_cell
    import sipq_pkg::*;
(
    input  wire                  i_clk,
    input  t_cell_ctl            i_ctl,
    input  wire                  i_valid,
    input  wire                  i_s_left,
    input  wire                  i_s_in,
    input  wire [KEY_WIDTH-1:0]  i_prev,
    input  wire [KEY_WIDTH-1:0]  i_next,
    output logic                 o_s_out,
    output logic [KEY_WIDTH-1:0] o_entry
);

    logic [KEY_WIDTH-1:0] r_entry;
    logic [KEY_WIDTH-1:0] n_entry;
    logic                 below;

    // held entry ranks below the new key under the current order
    assign below   = i_ctl.mode ? (r_entry > i_ctl.key) : (r_entry < i_ctl.key);
    // everything from this cell to the tail gives way to the new key
    assign o_s_out = !i_valid || (below && i_s_in);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_s_left) begin
                n_entry = i_prev;
            end else if (o_s_out) begin
                n_entry = i_ctl.key;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

### src/sorted_insert_priority_queue.sv
`default_nettype none
// Sorted priority queue built as a row of key cells.
// Request channel: i_start with i_req {req_type, key}; taken when i_start is
// high and o_busy is low. o_busy is high only while reset is held; otherwise
// a request is taken every cycle.
// Response: o_valid strobes for one cycle, in the cycle after the request, with
// o_rsp {front_key, status, entry_count}. There is no backpressure on the
// response side; the receiver must take it in that cycle.
// Insert: the key takes its ordered place, the cells behind it shift back in
// the same cycle. Remove: cell 0 is returned and all cells shift forward.
// Throughput 1 request per cycle; the rank chain across the cells sets
// the critical path.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data.
// Index 0 capacity in use (clamped to the built depth), index 1 order mode
// (0 largest first, 1 smallest first). Write only while idle.
// Reset (synchronous, active low) empties the queue, capacity goes to 16,
// order mode to 0. Key storage is not cleared.
module sorted_insert_priority_queue
    import sipq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  t_req       i_req,
    output logic       o_busy,
    output logic       o_valid,
    output t_rsp       o_rsp,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [4:0]  i_cfg_data
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CAP_W-1:0] r_cap;
    logic             r_mode;
    logic             r_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic [CAP_W-1:0] cap_eff;
    logic             full;
    logic             accept;
    t_cell_ctl        ctl;

    logic [DEPTH:0]     s_chain;
    logic [DEPTH-1:0]   cell_valid;
    logic [KEY_WIDTH-1:0] entries [DEPTH];

    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_rsp       = r_rsp;
    assign accept      = i_start && !o_busy;

    assign cap_eff = (r_cap > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : r_cap;
    assign full    = (32'(r_count) >= 32'(cap_eff));

    assign ctl.ins  = accept && (i_req.req_type == REQ_INSERT) && !full;
    assign ctl.rem  = accept && (i_req.req_type == REQ_REMOVE) && (r_count != '0);
    assign ctl.mode = r_mode;
    assign ctl.key  = KEY_WIDTH'(i_req.key);

    assign s_chain[DEPTH] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                 s_left;
            logic [KEY_WIDTH-1:0] prev_e;
            logic [KEY_WIDTH-1:0] next_e;

            assign cell_valid[g] = (r_count > CNT_W'(g));
            if (g == 0) begin : g_head
                assign s_left = 1'b0;
                assign prev_e = '0;
            end else begin : g_body
                assign s_left = s_chain[g-1];
                assign prev_e = entries[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign next_e = '0;
            end else begin : g_mid
                assign next_e = entries[g+1];
            end

            sipq_cell u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_valid  (cell_valid[g]),
                .i_s_left (s_left),
                .i_s_in   (s_chain[g+1]),
                .i_prev   (prev_e),
                .i_next   (next_e),
                .o_s_out  (s_chain[g]),
                .o_entry  (entries[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_rsp   = '0;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count         = r_count - CNT_W'(1);
            n_rsp.front_key = 32'(entries[0]);
        end
        if (accept) begin
            if (i_req.req_type == REQ_INSERT && full) begin
                n_rsp.status = ST_FULL;
            end else if (i_req.req_type == REQ_REMOVE && r_count == '0) begin
                n_rsp.status = ST_EMPTY;
            end else begin
                n_rsp.status = ST_DONE;
            end
        end
        n_rsp.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_W'(16);
            r_mode  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CAPACITY: r_cap  <= i_cfg_data;
                    CFG_ORDER:    r_mode <= i_cfg_data[0];
                    default:      r_mode <= r_mode;
                endcase
            end
        end
        r_rsp <= n_rsp;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("missing response strobe");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_INSERT && full) |=> $stable(r_count))
        else $error("dropped insert changed count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == ST_EMPTY) |->
            (o_rsp.front_key == '0 && o_rsp.entry_count == '0))
        else $error("empty remove returned data");

endmodule
`default_nettype wire
